// ===== rtl/baq_pkg.sv =====
// Shared types and constants for the bounded-concurrency admission queue.
// Used by baq_ctrl, baq_datapath and the top level; depends on nothing.
package baq_pkg;

  // Defaults for the top-level parameters
  localparam int DefQueueDepth = 32;
  localparam int DefTagBits    = 16;

  // Fixed field widths
  localparam int KindW   = 2;
  localparam int TagW    = 16;
  localparam int CodeW   = 2;
  localparam int ActiveW = 5;
  localparam int WaitW   = 7;
  localparam int StampW  = 16;

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ACTIVE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LIFETIME   = 2'd1;

  // Register reset values
  localparam logic [ActiveW-1:0] MAX_ACTIVE_RST = 5'd16;
  localparam logic [StampW-1:0]  LIFETIME_RST   = 16'd20;
  localparam logic [ActiveW-1:0] WORKER_CAP     = 5'd16;

  // Input kinds
  localparam logic [KindW-1:0] KIND_REQUEST = 2'd0;
  localparam logic [KindW-1:0] KIND_FINISH  = 2'd1;
  localparam logic [KindW-1:0] KIND_TICK    = 2'd2;

  // Result codes
  localparam logic [CodeW-1:0] EVT_LAUNCH  = 2'd0;
  localparam logic [CodeW-1:0] EVT_TIMEOUT = 2'd1;
  localparam logic [CodeW-1:0] EVT_REJECT  = 2'd2;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [TagW-1:0]  request_tag;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0]   event_code;
    logic [TagW-1:0]    result_tag;
    logic [ActiveW-1:0] active_count;
    logic [WaitW-1:0]   waiting_count;
    logic               last_of_run;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // capture the input item
    logic push;       // append request at tail
    logic busy_dec;   // free one worker slot
    logic tick;       // advance time
    logic rd_head;    // read queue head into read registers
    logic launch;     // pop head, start worker, emit launch
    logic reject;     // emit reject for captured tag
    logic pop;        // pop head for timeout
    logic hold_load;  // park popped head as pending timeout
    logic emit_hold;  // emit pending timeout
  } baq_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic busy_nonzero;
    logic below_limit;
    logic launch_more;
    logic expired;
    logic out_free;
  } baq_sts_t;

endpackage

// ===== rtl/baq_ctrl.sv =====
// Controller state machine for the admission queue.
// Depends on baq_pkg; drives baq_datapath through baq_cmd_t.
module baq_ctrl import baq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [KindW-1:0] in_kind_i,
  output logic             in_ready_o,
  input  baq_sts_t         sts_i,
  output baq_cmd_t         cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LCHK  = 3'd1;
  localparam logic [2:0] S_LRD   = 3'd2;
  localparam logic [2:0] S_LEMIT = 3'd3;
  localparam logic [2:0] S_REJ   = 3'd4;
  localparam logic [2:0] S_TRD   = 3'd5;
  localparam logic [2:0] S_TCHK  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       hold_q, hold_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Sequence one item at a time
  always_comb begin
    state_d = state_q;
    hold_d  = hold_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (in_kind_i)
            KIND_REQUEST: begin
              if (sts_i.full) begin
                state_d = S_REJ;
              end else begin
                cmd_o.push = 1'b1;
                state_d    = S_LCHK;
              end
            end
            KIND_FINISH: begin
              if (sts_i.busy_nonzero) begin
                cmd_o.busy_dec = 1'b1;
                state_d        = S_LCHK;
              end
            end
            KIND_TICK: begin
              cmd_o.tick = 1'b1;
              hold_d     = 1'b0;
              state_d    = S_TRD;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_LCHK: begin
        if (sts_i.below_limit && !sts_i.empty) begin
          state_d = S_LRD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_LRD: begin
        cmd_o.rd_head = 1'b1;
        state_d       = S_LEMIT;
      end
      S_LEMIT: begin
        if (sts_i.out_free) begin
          cmd_o.launch = 1'b1;
          state_d      = sts_i.launch_more ? S_LRD : S_IDLE;
        end
      end
      S_REJ: begin
        if (sts_i.out_free) begin
          cmd_o.reject = 1'b1;
          state_d      = S_LCHK;
        end
      end
      S_TRD: begin
        cmd_o.rd_head = 1'b1;
        state_d       = S_TCHK;
      end
      S_TCHK: begin
        // Wait while a pending timeout cannot leave yet
        if (!hold_q || sts_i.out_free) begin
          cmd_o.emit_hold = hold_q;
          if (sts_i.expired) begin
            cmd_o.pop       = 1'b1;
            cmd_o.hold_load = 1'b1;
            hold_d          = 1'b1;
            state_d         = S_TRD;
          end else begin
            hold_d  = 1'b0;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hold_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      hold_q  <= hold_d;
    end
  end

endmodule

// ===== rtl/baq_datapath.sv =====
// Datapath of the admission queue: config, counters, queue memory, output register.
// Depends on baq_pkg; driven by baq_ctrl through baq_cmd_t.
module baq_datapath import baq_pkg::*; #(
  parameter int QUEUE_DEPTH = DefQueueDepth,
  parameter int TAG_BITS    = DefTagBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [TagW-1:0]     in_tag_i,
  output out_item_t           out_data_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  baq_cmd_t            cmd_i,
  output baq_sts_t            sts_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  // Configuration registers
  logic [ActiveW-1:0] max_active_q;
  logic [StampW-1:0]  lifetime_q;

  // Queue and counters
  logic [TAG_BITS-1:0] tag_mem   [QUEUE_DEPTH];
  logic [StampW-1:0]   stamp_mem [QUEUE_DEPTH];
  logic [PtrW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]     fill_q, fill_d;
  logic [ActiveW-1:0]  busy_q, busy_d;
  logic [StampW-1:0]   time_q;
  logic [TAG_BITS-1:0] req_tag_q, tag_in;
  logic [TAG_BITS-1:0] rd_tag_q, hold_tag_q;
  logic [StampW-1:0]   rd_stamp_q;
  logic [CntW-1:0]     hold_wait_q;

  // Output register
  out_item_t out_q, out_d;
  logic      out_valid_q, out_valid_d;

  logic [ActiveW-1:0] limit;
  logic [ActiveW-1:0] busy_inc;
  logic [CntW-1:0]    fill_dec;
  logic [StampW-1:0]  age;
  logic               head_pop;
  logic [CntW:0]      ptr_sum;
  logic [PtrW-1:0]    tail_expect;

  // Fit the 16-bit tag into storage width
  always_comb begin
    logic [31:0] wide;
    wide   = 32'(in_tag_i);
    tag_in = wide[TAG_BITS-1:0];
  end

  function automatic logic [TagW-1:0] tag_out(input logic [TAG_BITS-1:0] t);
    logic [31:0] wide;
    wide = '0;
    wide[TAG_BITS-1:0] = t;
    return wide[TagW-1:0];
  endfunction

  // Clamp the worker limit to 1..16
  always_comb begin
    if (max_active_q == '0) begin
      limit = ActiveW'(1);
    end else if (max_active_q > WORKER_CAP) begin
      limit = WORKER_CAP;
    end else begin
      limit = max_active_q;
    end
  end

  assign busy_inc = busy_q + ActiveW'(1);
  assign fill_dec = fill_q - CntW'(1);
  assign age      = time_q - rd_stamp_q;
  assign head_pop = cmd_i.launch | cmd_i.pop;

  assign sts_o.full         = (fill_q == CntFull);
  assign sts_o.empty        = (fill_q == '0);
  assign sts_o.busy_nonzero = (busy_q != '0);
  assign sts_o.below_limit  = (busy_q < limit);
  assign sts_o.launch_more  = (busy_inc < limit) && (fill_q > CntW'(1));
  assign sts_o.expired      = (fill_q != '0) && (age > lifetime_q);
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  // Advance pointers and counters
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    busy_d = busy_q;
    if (head_pop) begin
      head_d = (head_q == PtrLast) ? '0 : head_q + PtrW'(1);
      fill_d = fill_dec;
    end
    if (cmd_i.push) begin
      tail_d = (tail_q == PtrLast) ? '0 : tail_q + PtrW'(1);
      fill_d = fill_q + CntW'(1);
    end
    if (cmd_i.launch) begin
      busy_d = busy_inc;
    end else if (cmd_i.busy_dec) begin
      busy_d = busy_q - ActiveW'(1);
    end
  end

  // Build the next result
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    priority if (cmd_i.launch) begin
      out_d.event_code    = EVT_LAUNCH;
      out_d.result_tag    = tag_out(rd_tag_q);
      out_d.active_count  = busy_inc;
      out_d.waiting_count = WaitW'(fill_dec);
      out_d.last_of_run   = !sts_o.launch_more;
      out_valid_d         = 1'b1;
    end else if (cmd_i.reject) begin
      out_d.event_code    = EVT_REJECT;
      out_d.result_tag    = tag_out(req_tag_q);
      out_d.active_count  = busy_q;
      out_d.waiting_count = WaitW'(fill_q);
      out_d.last_of_run   = !sts_o.below_limit;
      out_valid_d         = 1'b1;
    end else if (cmd_i.emit_hold) begin
      out_d.event_code    = EVT_TIMEOUT;
      out_d.result_tag    = tag_out(hold_tag_q);
      out_d.active_count  = busy_q;
      out_d.waiting_count = WaitW'(hold_wait_q);
      out_d.last_of_run   = !sts_o.expired;
      out_valid_d         = 1'b1;
    end else begin
      // Hold the current result
      out_d = out_q;
    end
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_active_q <= MAX_ACTIVE_RST;
      lifetime_q   <= LIFETIME_RST;
      head_q       <= '0;
      tail_q       <= '0;
      fill_q       <= '0;
      busy_q       <= '0;
      time_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_MAX_ACTIVE) begin
        max_active_q <= cfg_data_i[ActiveW-1:0];
      end
      if (cfg_we_i && cfg_idx_i == CFG_LIFETIME) begin
        lifetime_q <= cfg_data_i[StampW-1:0];
      end
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.tick) begin
        time_q <= time_q + StampW'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.accept) begin
      req_tag_q <= tag_in;
    end
    if (cmd_i.hold_load) begin
      hold_tag_q  <= rd_tag_q;
      hold_wait_q <= fill_dec;
    end
  end

  // Queue memory: write at tail, registered read at head
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      tag_mem[tail_q]   <= tag_in;
      stamp_mem[tail_q] <= time_q;
    end
    if (cmd_i.rd_head) begin
      rd_tag_q   <= tag_mem[head_q];
      rd_stamp_q <= stamp_mem[head_q];
    end
  end

  // Expected tail from head and fill
  always_comb begin
    ptr_sum     = (CntW+1)'(head_q) + (CntW+1)'(fill_q);
    tail_expect = (ptr_sum >= (CntW+1)'(QUEUE_DEPTH)) ?
                  PtrW'(ptr_sum - (CntW+1)'(QUEUE_DEPTH)) : PtrW'(ptr_sum);
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntFull)
    else $error("queue fill exceeds depth");

  a_busy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q <= WORKER_CAP)
    else $error("active workers exceed cap");

  a_ptr_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q == tail_expect)
    else $error("tail pointer disagrees with head and fill");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop |-> fill_q != '0)
    else $error("pop from empty queue");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (fill_q != CntFull && !head_pop))
    else $error("push into full queue or with a pop");

endmodule

// ===== rtl/bounded_concurrency_admission_queue.sv =====
// Top level of the bounded-concurrency admission queue.
// Depends on baq_pkg; instantiates baq_ctrl and baq_datapath.
//
//  port group   direction  handshake              payload
//  in_*         in         in_valid_i/in_ready_o  in_item_t (kind, request_tag)
//  out_*        out        out_valid_o/out_ready_i out_item_t (code, tag, counts, last)
//  cfg_*        in         cfg_we_i (no wait)     cfg_idx_i, cfg_data_i
//
// One item at a time. A request with room is pushed, checked, read and launched; each
// further launch repeats the head read and launch, due to the single registered read
// port of the queue memory. A finish frees a worker and goes on alike; a tick reads and
// checks the head, again after each timeout. A finish with no worker or an unused kind
// stays idle. Reset clears counters and pointers at once; queue memory is not cleared.
// The output register lets a new item in while the last result waits to leave.
module bounded_concurrency_admission_queue import baq_pkg::*; #(
  parameter int QUEUE_DEPTH = DefQueueDepth,
  parameter int TAG_BITS    = DefTagBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o
);

  baq_cmd_t cmd;
  baq_sts_t sts;

  // Sequence each item
  baq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_data_i.kind),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold queue, counters and results
  baq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_tag_i    (in_data_i.request_tag),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
